/* src/pli_pkg.sv */
// pli_pkg: shared types and constants of the peak limiter
// widths, register defaults, config indexes, sequencer states and the iterative unit command/status structs
// no dependencies
package pli_pkg;

  localparam int unsigned SampleBitsDef = 32;
  localparam int unsigned PressureW     = 32;
  localparam int unsigned OutW          = 18;
  localparam int unsigned OutBytesW     = 24;
  localparam int unsigned RcW           = 24;
  localparam int unsigned ScaleW        = 16;
  localparam int unsigned QuotW         = 17;
  localparam int unsigned CfgIndexW     = 8;
  localparam int unsigned CfgDataW      = 32;
  localparam int unsigned StepW         = $clog2((RcW > QuotW) ? RcW : QuotW);

  localparam logic [RcW-1:0]    RcReset    = 24'd16773721;
  localparam logic [ScaleW-1:0] ScaleReset = 16'd3277;
  localparam int unsigned       UnityLevel = 65536;

  localparam logic [CfgIndexW-1:0] CfgRelease = 8'd0;
  localparam logic [CfgIndexW-1:0] CfgScale   = 8'd1;

  typedef enum logic {
    OpMul,
    OpDiv
  } pli_op_e;

  typedef struct packed {
    logic    start;
    pli_op_e op;
  } pli_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pli_stat_t;

  typedef enum logic [2:0] {
    StIdle,
    StScale,
    StDecay,
    StUpdate,
    StDivStart,
    StDivide,
    StFinish
  } pli_state_e;

endpackage

/* src/peak_limiter_instant_attack_unit.sv */
// peak_limiter_instant_attack_unit: top level of the peak limiter
// scales the sample, tracks the peak envelope and divides by it when above unity
// depends on pli_pkg and pli_iter_unit
//
// usage:
//   s_axis carries one pressure sample per beat (Q15.16, signed, tdata bits 31:0).
//   m_axis returns one beat per sample: tdata[17:0] the limited sample (Q1.16),
//   tuser the gain reduction flag.
//   cfg_* writes release coefficient (index 0) and input scale (index 1);
//   other indexes are dropped. cfg_ready_o is always high; write only when idle.
// processing:
//   an accepted sample is scaled, decayed and, when the envelope rises above unity,
//   divided, then waits for the output register if it is stalled. the work runs on the
//   shared adder: 24 shift-add steps for the decay, 17 restoring divide steps.
//   s_axis_tready is high only while the sequencer is idle.
// reset:
//   envelope cleared to zero, registers back to their defaults, no beat pending.
// stall:
//   a finished result waits in the output register; the next sample is accepted
//   and worked on meanwhile, and its result waits until the register frees up.
module peak_limiter_instant_attack_unit
  import pli_pkg::*;
#(
  parameter int unsigned SampleBits = SampleBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [PressureW-1:0] s_axis_tdata,  // pressure_sample
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutBytesW-1:0] m_axis_tdata,  // limited_sample, zero pad
  output logic                 m_axis_tuser,  // gain_reduced
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned ProdW = PressureW + ScaleW + 1;
  localparam int unsigned WideW = ProdW + 1;
  localparam logic signed [WideW-1:0] SMax = (WideW'(1) <<< (SampleBits - 1)) - WideW'(1);
  localparam logic signed [WideW-1:0] SMin = -SMax - WideW'(1);
  localparam logic signed [WideW-1:0] RoundHalf = WideW'(32768);
  localparam logic [SampleBits:0]     Unity = (SampleBits + 1)'(UnityLevel);

  pli_state_e state_q, state_d;

  logic [RcW-1:0]        rc_q;
  logic [ScaleW-1:0]     scale_q;
  logic [SampleBits-1:0] env_q;
  logic [SampleBits-1:0] env_d;
  logic                  env_we;

  logic signed [ProdW-1:0] prod_q;
  logic [SampleBits-1:0]   mag_q;
  logic                    neg_q;
  logic                    red_q;

  logic signed [WideW-1:0] rnd_w;
  logic signed [WideW-1:0] x_w;
  logic [SampleBits-1:0]   x_sat;
  logic [SampleBits-1:0]   x_mag;

  logic                  out_valid_q;
  logic [OutW-1:0]       out_data_q;
  logic                  out_red_q;
  logic [OutW-1:0]       res_mag;
  logic [OutW-1:0]       res_val;
  logic                  out_load;

  pli_cmd_t              unit_cmd;
  pli_stat_t             unit_stat;
  logic [SampleBits-1:0] unit_prod;
  logic [QuotW-1:0]      unit_quot;

  pli_iter_unit #(
    .SampleBits(SampleBits)
  ) u_iter (
    .clk_i,
    .rst_ni,
    .cmd_i  (unit_cmd),
    .stat_o (unit_stat),
    .env_i  (env_q),
    .coef_i (rc_q),
    .mag_i  (mag_q),
    .prod_o (unit_prod),
    .quot_o (unit_quot)
  );

  // rounding, floor shift and saturation of the scaled sample, and its magnitude
  always_comb begin
    rnd_w = WideW'(prod_q) + RoundHalf;
    x_w   = rnd_w >>> 16;
    if (x_w > SMax) begin
      x_sat = SMax[SampleBits-1:0];
    end else if (x_w < SMin) begin
      x_sat = SMin[SampleBits-1:0];
    end else begin
      x_sat = x_w[SampleBits-1:0];
    end
    x_mag = x_sat[SampleBits-1] ? (~x_sat + 1'b1) : x_sat;
  end

  always_comb begin
    env_d   = (mag_q > unit_prod) ? mag_q : unit_prod;
    res_mag = red_q ? OutW'(unit_quot) : OutW'(mag_q);
    res_val = neg_q ? (~res_mag + 1'b1) : res_mag;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    unit_cmd      = '{start: 1'b0, op: OpMul};
    env_we        = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = StScale;
        end
      end
      StScale: begin
        unit_cmd = '{start: 1'b1, op: OpMul};
        state_d  = StDecay;
      end
      StDecay: begin
        if (unit_stat.done) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        env_we  = 1'b1;
        state_d = ({1'b0, env_d} > Unity) ? StDivStart : StFinish;
      end
      StDivStart: begin
        unit_cmd = '{start: 1'b1, op: OpDiv};
        state_d  = StDivide;
      end
      StDivide: begin
        if (unit_stat.done) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q        <= RcReset;
      scale_q     <= ScaleReset;
      env_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && (cfg_index_i == CfgRelease)) begin
        rc_q <= cfg_data_i[RcW-1:0];
      end
      if (cfg_valid_i && (cfg_index_i == CfgScale)) begin
        scale_q <= cfg_data_i[ScaleW-1:0];
      end
      if (env_we) begin
        env_q <= env_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      prod_q <= $signed(s_axis_tdata) * $signed({1'b0, scale_q});
    end
    if (state_q == StScale) begin
      mag_q <= x_mag;
      neg_q <= x_sat[SampleBits-1];
    end
    if (env_we) begin
      red_q <= ({1'b0, env_d} > Unity);
    end
    if (out_load) begin
      out_data_q <= res_val;
      out_red_q  <= red_q;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutBytesW - OutW)'(0), out_data_q};
  assign m_axis_tuser  = out_red_q;

  a_one_beat_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat accepted while a sample is in work");

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_cmd.start |-> !unit_stat.busy)
    else $error("shared unit started while busy");

  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_stat.done |-> (state_q == StDecay) || (state_q == StDivide))
    else $error("shared unit finished outside a wait state");

  a_output_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[OutW-1:0]) >= -$signed(OutW'(UnityLevel))) &&
                      ($signed(m_axis_tdata[OutW-1:0]) <= $signed(OutW'(UnityLevel))))
    else $error("limited sample above unity");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid)
    else $error("result lost at output register");

endmodule

/* src/pli_iter_unit.sv */
// pli_iter_unit: shared add/subtract unit run bit by bit
// does the envelope decay multiply (shift-add) and the gain divide (restoring)
// depends on pli_pkg
module pli_iter_unit
  import pli_pkg::*;
#(
  parameter int unsigned SampleBits = SampleBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pli_cmd_t              cmd_i,
  output pli_stat_t             stat_o,
  input  logic [SampleBits-1:0] env_i,
  input  logic [RcW-1:0]        coef_i,
  input  logic [SampleBits-1:0] mag_i,
  output logic [SampleBits-1:0] prod_o,
  output logic [QuotW-1:0]      quot_o
);

  localparam int unsigned AddW = SampleBits + 2;

  logic                  busy_q;
  logic                  done_q;
  pli_op_e               op_q;
  logic [StepW-1:0]      cnt_q;
  logic [SampleBits-1:0] acc_q;
  logic [RcW-1:0]        mr_q;
  logic [SampleBits:0]   rem_q;
  logic [QuotW-1:0]      quot_q;

  logic [AddW-1:0]       add_a;
  logic [AddW-1:0]       add_b;
  logic                  add_sub;
  logic [AddW-1:0]       add_sum;
  logic                  div_neg;
  logic [SampleBits-1:0] div_sel;

  // one adder shared by both operations
  always_comb begin
    case (op_q)
      OpDiv: begin
        add_a   = {1'b0, rem_q};
        add_b   = {2'b00, env_i};
        add_sub = 1'b1;
      end
      default: begin
        add_a   = {2'b00, acc_q};
        add_b   = mr_q[0] ? {2'b00, env_i} : '0;
        add_sub = 1'b0;
      end
    endcase
    add_sum = add_a + (add_sub ? ~add_b : add_b) + AddW'(add_sub);
    div_neg = add_sum[AddW-1];
    div_sel = div_neg ? rem_q[SampleBits-1:0] : add_sum[SampleBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OpMul;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        op_q   <= cmd_i.op;
        cnt_q  <= (cmd_i.op == OpDiv) ? StepW'(QuotW - 1) : StepW'(RcW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_q  <= '0;
      mr_q   <= coef_i;
      rem_q  <= {1'b0, mag_i};
      quot_q <= '0;
    end else if (busy_q) begin
      case (op_q)
        OpDiv: begin
          rem_q  <= {div_sel, 1'b0};
          quot_q <= {quot_q[QuotW-2:0], ~div_neg};
        end
        default: begin
          acc_q <= add_sum[SampleBits:1];
          mr_q  <= mr_q >> 1;
        end
      endcase
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;
  assign quot_o      = quot_q;

endmodule
